// File: rtl/debounced_signal_auto_switch_defines.svh
// assertion macros used by the checker file of the auto-switch block
`ifndef DEBOUNCED_SIGNAL_AUTO_SWITCH_DEFINES_SVH
`define DEBOUNCED_SIGNAL_AUTO_SWITCH_DEFINES_SVH

// concurrent check, masked while reset is asserted
`define DSAS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dsas assertion failed");

// concurrent check that also holds during reset
`define DSAS_ASSERT_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("dsas assertion failed");

`endif

// File: rtl/dsas_pkg.sv
// types, constants and helpers of the debounced signal auto-switch block
package dsas_pkg;

  // number of switcher inputs, only the lower sixteen are tracked
  localparam int unsigned MaxInputs = 16;
  localparam int unsigned LaneW     = 16;
  localparam int unsigned LaneLimit = (MaxInputs > LaneW) ? LaneW : MaxInputs;
  localparam int unsigned CountW    = 5;
  localparam int unsigned NumW      = 8;
  localparam int unsigned TickW     = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [TickW-1:0] DebounceReset = TickW'(500);

  typedef enum logic [1:0] {
    OP_TICK   = 2'b00,
    OP_REPORT = 2'b01,
    OP_SELECT = 2'b10
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'b00,
    ACT_ANNOUNCE = 2'b01,
    ACT_RESTORE  = 2'b10,
    ACT_SWITCH   = 2'b11
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTO_SWITCH = 1'b0,
    CFG_DEBOUNCE    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [LaneW-1:0]  sig_bits;
    logic [CountW-1:0] sig_count;
    logic [NumW-1:0]   input_number;
  } in_t;

  typedef struct packed {
    action_e         action;
    logic [NumW-1:0] target_input;
    logic [NumW-1:0] selected_input;
  } out_t;

  typedef struct packed {
    logic             auto_switch;
    logic [TickW-1:0] debounce_ticks;
  } cfg_t;

  // low n lanes set, all lanes for n of sixteen or more
  function automatic logic [LaneW-1:0] lane_mask(logic [CountW-1:0] n);
    logic [LaneW-1:0] m;
    m = '0;
    for (int i = 0; i < LaneW; i++) begin
      m[i] = (CountW'(i) < n);
    end
    return m;
  endfunction

endpackage

// File: rtl/dsas_cfg_regs.sv
// configuration registers of the auto-switch block
module dsas_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dsas_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dsas_pkg::CfgDataW-1:0]  cfg_data_i,
  output dsas_pkg::cfg_t                 cfg_o
);

  dsas_pkg::cfg_t cfg_q, cfg_d;

  // register index decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (dsas_pkg::cfg_idx_e'(cfg_index_i))
        dsas_pkg::CFG_AUTO_SWITCH: cfg_d.auto_switch = cfg_data_i[0];
        dsas_pkg::CFG_DEBOUNCE:    cfg_d.debounce_ticks = cfg_data_i[dsas_pkg::TickW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_switch    <= 1'b1;
      cfg_q.debounce_ticks <= dsas_pkg::DebounceReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/dsas_core.sv
// tracking state and combinational decision logic for one item
module dsas_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  dsas_pkg::in_t  item_i,
  input  dsas_pkg::cfg_t cfg_i,
  output dsas_pkg::out_t res_o
);

  logic [dsas_pkg::LaneW-1:0]  pend_bits_q, pend_bits_d;
  logic [dsas_pkg::LaneW-1:0]  stable_bits_q, stable_bits_d;
  logic [dsas_pkg::CountW-1:0] pend_count_q, pend_count_d;
  logic [dsas_pkg::TickW-1:0]  elapsed_q, elapsed_d;
  logic                        seen_q, seen_d;
  logic                        all_lost_q, all_lost_d;
  logic [dsas_pkg::NumW-1:0]   cur_sel_q, cur_sel_d;

  logic [dsas_pkg::CountW-1:0] rep_count;
  logic [dsas_pkg::LaneW-1:0]  rep_bits;
  logic                        rep_changed;
  logic [dsas_pkg::LaneW-1:0]  pend_mask;
  logic [dsas_pkg::TickW-1:0]  elapsed_inc;
  logic                        tick_commit;
  logic [dsas_pkg::LaneW-1:0]  stable_new;
  logic [dsas_pkg::LaneW-1:0]  lit;
  logic [dsas_pkg::CountW-1:0] highest;

  // report clipping to the tracked lanes
  assign rep_count = (item_i.sig_count > dsas_pkg::CountW'(dsas_pkg::LaneLimit)) ?
                     dsas_pkg::CountW'(dsas_pkg::LaneLimit) : item_i.sig_count;
  assign rep_bits    = item_i.sig_bits & dsas_pkg::lane_mask(rep_count);
  assign rep_changed = (rep_count != pend_count_q) || (rep_bits != pend_bits_q);

  // saturating elapsed count and debounce test
  assign pend_mask   = dsas_pkg::lane_mask(pend_count_q);
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + dsas_pkg::TickW'(1);
  assign tick_commit = cfg_i.auto_switch && (pend_count_q != '0) && seen_q &&
                       (((pend_bits_q ^ stable_bits_q) & pend_mask) != '0) &&
                       (elapsed_inc >= cfg_i.debounce_ticks);
  assign stable_new  = (stable_bits_q & ~pend_mask) | (pend_bits_q & pend_mask);
  assign lit         = stable_new & pend_mask;

  // priority encode, highest lit lane wins, one-based
  always_comb begin
    highest = '0;
    for (int i = 0; i < dsas_pkg::LaneW; i++) begin
      if (lit[i]) begin
        highest = dsas_pkg::CountW'(i + 1);
      end
    end
  end

  // next state and result per opcode
  always_comb begin
    pend_bits_d   = pend_bits_q;
    stable_bits_d = stable_bits_q;
    pend_count_d  = pend_count_q;
    elapsed_d     = elapsed_q;
    seen_d        = seen_q;
    all_lost_d    = all_lost_q;
    cur_sel_d     = cur_sel_q;
    res_o.action       = dsas_pkg::ACT_NONE;
    res_o.target_input = '0;
    unique case (dsas_pkg::opcode_e'(item_i.opcode))
      dsas_pkg::OP_TICK: begin
        elapsed_d = elapsed_inc;
        if (tick_commit) begin
          stable_bits_d = stable_new;
          if (highest == '0) begin
            all_lost_d = 1'b1;
          end else if (dsas_pkg::NumW'(highest) == cur_sel_q) begin
            if (all_lost_q) begin
              all_lost_d         = 1'b0;
              res_o.action       = dsas_pkg::ACT_RESTORE;
              res_o.target_input = dsas_pkg::NumW'(highest);
            end
          end else begin
            all_lost_d         = 1'b0;
            res_o.action       = dsas_pkg::ACT_SWITCH;
            res_o.target_input = dsas_pkg::NumW'(highest);
          end
        end
      end
      dsas_pkg::OP_REPORT: begin
        if ((item_i.sig_count != '0) && rep_changed) begin
          pend_bits_d  = rep_bits;
          pend_count_d = rep_count;
          elapsed_d    = '0;
          seen_d       = 1'b1;
        end
      end
      dsas_pkg::OP_SELECT: begin
        if (item_i.input_number != '0) begin
          cur_sel_d          = item_i.input_number;
          res_o.action       = dsas_pkg::ACT_ANNOUNCE;
          res_o.target_input = item_i.input_number;
        end
      end
      default: begin
        cur_sel_d = cur_sel_q;
      end
    endcase
    res_o.selected_input = cur_sel_d;
  end

  // state advances only on a processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q   <= '0;
      stable_bits_q <= '0;
      pend_count_q  <= '0;
      elapsed_q     <= '0;
      seen_q        <= 1'b0;
      all_lost_q    <= 1'b0;
      cur_sel_q     <= '0;
    end else if (fire_i) begin
      pend_bits_q   <= pend_bits_d;
      stable_bits_q <= stable_bits_d;
      pend_count_q  <= pend_count_d;
      elapsed_q     <= elapsed_d;
      seen_q        <= seen_d;
      all_lost_q    <= all_lost_d;
      cur_sel_q     <= cur_sel_d;
    end
  end

endmodule

// File: rtl/debounced_signal_auto_switch.sv
// Debounced signal auto-switch: top level with input and result registers.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one item per
// transfer: a millisecond tick, a signal presence report or a selected-input
// report. Output channel (out_valid_o / out_stall_i / out_data_o) gives exactly
// one result per item, in order: an action, its target input and the current
// selection. The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) sets
// auto-switch enable and the debounce time; write it only while idle.
// An accepted item is held in the input register while the decision logic
// runs; its result moves into the output register when that register is
// empty or not stalled. One item per cycle is sustained while the receiver
// does not stall; the limit is the single pass through the decision logic,
// which reads state updated by the item before it.
// Reset clears all tracking state, empties both registers and loads the
// configuration defaults (auto-switch on, 500 ticks).
// When the receiver stalls, the result holds and one more item is still
// taken into an empty input register; after that in_stall_o rises.
module debounced_signal_auto_switch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dsas_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dsas_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [dsas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dsas_pkg::CfgDataW-1:0] cfg_data_i
);

  dsas_pkg::cfg_t cfg;
  dsas_pkg::in_t  in_q;
  dsas_pkg::out_t out_q;
  dsas_pkg::out_t res;
  logic           in_vld_q, in_vld_d;
  logic           out_vld_q, out_vld_d;
  logic           out_ready;
  logic           fire;
  logic           in_take;

  dsas_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dsas_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // handshake between the two register stages
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take || (in_vld_q && !fire);
  assign out_vld_d  = fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/dsas_checker.sv
// port-level checker for the auto-switch block and its bind
`include "debounced_signal_auto_switch_defines.svh"

module dsas_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input dsas_pkg::out_t out_data_o
);

  // no result shown in the cycle after reset is seen
  `DSAS_ASSERT_ANY(a_rst_no_result, clk_i, !rst_ni |=> !out_valid_o)

  // a stalled result holds
  `DSAS_ASSERT(a_out_hold, clk_i, rst_ni,
               out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // no action carries no target
  `DSAS_ASSERT(a_none_target, clk_i, rst_ni,
               out_valid_o && out_data_o.action == dsas_pkg::ACT_NONE |->
               out_data_o.target_input == '0)

  // announce and restore concern the current selection
  `DSAS_ASSERT(a_sel_target, clk_i, rst_ni,
               out_valid_o && (out_data_o.action == dsas_pkg::ACT_ANNOUNCE ||
               out_data_o.action == dsas_pkg::ACT_RESTORE) |->
               out_data_o.target_input == out_data_o.selected_input)

  // a switch goes to a real input other than the current one
  `DSAS_ASSERT(a_switch_target, clk_i, rst_ni,
               out_valid_o && out_data_o.action == dsas_pkg::ACT_SWITCH |->
               out_data_o.target_input != '0 &&
               out_data_o.target_input != out_data_o.selected_input)

endmodule

bind debounced_signal_auto_switch dsas_checker u_dsas_checker (.*);

// File: tb/dsas_checker.sv
// checker for the auto-switch block: follows transfers, predicts results and compares
module dsas_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  dsas_pkg::in_t                 in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  dsas_pkg::out_t                out_data_i,
  input  logic                          cfg_we_i,
  input  logic [dsas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dsas_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            errors_o,
  output int                            awaited_o
);

  // configuration copy
  logic                       auto_on;
  logic [dsas_pkg::TickW-1:0] debounce;

  // tracking state
  logic [dsas_pkg::LaneW-1:0]  pend_bits;
  logic [dsas_pkg::LaneW-1:0]  stable;
  logic [dsas_pkg::CountW-1:0] pend_cnt;
  logic [dsas_pkg::TickW-1:0]  elapsed;
  logic                        seen;
  logic                        lost;
  logic [dsas_pkg::NumW-1:0]   sel;

  dsas_pkg::out_t awaited_results[$];

  // low n lanes of a report, all of them from sixteen on
  function automatic logic [dsas_pkg::LaneW-1:0] cover_mask(logic [dsas_pkg::CountW-1:0] n);
    if (n >= dsas_pkg::CountW'(dsas_pkg::LaneW)) begin
      return '1;
    end
    return (dsas_pkg::LaneW'(1) << n) - dsas_pkg::LaneW'(1);
  endfunction

  // next result of the switcher for one item, state advanced as a side effect
  function automatic dsas_pkg::out_t switch_decision(dsas_pkg::in_t item);
    dsas_pkg::out_t              res;
    logic [dsas_pkg::LaneW-1:0]  mask;
    logic [dsas_pkg::LaneW-1:0]  bits;
    logic [dsas_pkg::CountW-1:0] cnt;
    int                          top_lane;
    res.action       = dsas_pkg::ACT_NONE;
    res.target_input = '0;
    case (item.opcode)
      dsas_pkg::OP_TICK: begin
        if (elapsed != '1) begin
          elapsed = elapsed + 1'b1;
        end
        mask = cover_mask(pend_cnt);
        if (auto_on && pend_cnt != '0 && seen && ((pend_bits ^ stable) & mask) != '0 &&
            elapsed >= debounce) begin
          stable = (stable & ~mask) | (pend_bits & mask);
          // highest covered lane with signal
          top_lane = 0;
          for (int i = dsas_pkg::LaneW; i >= 1; i--) begin
            if (top_lane == 0 && i <= pend_cnt && stable[i-1]) begin
              top_lane = i;
            end
          end
          if (top_lane == 0) begin
            lost = 1'b1;
          end else if (top_lane == sel) begin
            if (lost) begin
              lost             = 1'b0;
              res.action       = dsas_pkg::ACT_RESTORE;
              res.target_input = dsas_pkg::NumW'(top_lane);
            end
          end else begin
            lost             = 1'b0;
            res.action       = dsas_pkg::ACT_SWITCH;
            res.target_input = dsas_pkg::NumW'(top_lane);
          end
        end
      end
      dsas_pkg::OP_REPORT: begin
        if (item.sig_count != '0) begin
          cnt  = (item.sig_count > dsas_pkg::CountW'(dsas_pkg::LaneLimit)) ?
                 dsas_pkg::CountW'(dsas_pkg::LaneLimit) : item.sig_count;
          bits = item.sig_bits & cover_mask(cnt);
          if (cnt != pend_cnt || bits != pend_bits) begin
            pend_bits = bits;
            pend_cnt  = cnt;
            elapsed   = '0;
            seen      = 1'b1;
          end
        end
      end
      dsas_pkg::OP_SELECT: begin
        if (item.input_number != '0) begin
          sel              = item.input_number;
          res.action       = dsas_pkg::ACT_ANNOUNCE;
          res.target_input = item.input_number;
        end
      end
      default: begin
      end
    endcase
    res.selected_input = sel;
    return res;
  endfunction

  // compare on result transfers, predict on input transfers, follow register writes
  always @(posedge clk_i or negedge rst_ni) begin : watch
    dsas_pkg::out_t want;
    if (!rst_ni) begin
      auto_on   = 1'b1;
      debounce  = dsas_pkg::DebounceReset;
      pend_bits = '0;
      stable    = '0;
      pend_cnt  = '0;
      elapsed   = '0;
      seen      = 1'b0;
      lost      = 1'b0;
      sel       = '0;
      awaited_results.delete();
      errors_o  = 0;
      awaited_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_data_i);
          errors_o++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data_i.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, out_data_i.action);
            errors_o++;
          end
          if (out_data_i.target_input !== want.target_input) begin
            $error("target_input: expected %0d, got %0d", want.target_input,
                   out_data_i.target_input);
            errors_o++;
          end
          if (out_data_i.selected_input !== want.selected_input) begin
            $error("selected_input: expected %0d, got %0d", want.selected_input,
                   out_data_i.selected_input);
            errors_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want            = switch_decision(in_data_i);
        awaited_results = {awaited_results, want};
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          dsas_pkg::CFG_AUTO_SWITCH: auto_on  = cfg_data_i[0];
          dsas_pkg::CFG_DEBOUNCE:    debounce = cfg_data_i[dsas_pkg::TickW-1:0];
          default: begin
          end
        endcase
      end
      awaited_o = awaited_results.size();
    end
  end

endmodule

// File: tb/testbench.sv
// top of the auto-switch testbench: clock, reset, stimulus, idling and verdict
module testbench;

  localparam logic [1:0] OP_UNUSED  = 2'b11;
  localparam int         StallLimit = 1000;

  logic                          clk_i;
  logic                          rst_n       = 1'b0;
  logic                          in_valid    = 1'b0;
  dsas_pkg::in_t                 in_data     = '0;
  logic                          out_stall   = 1'b0;
  logic                          cfg_we      = 1'b0;
  logic [dsas_pkg::CfgIdxW-1:0]  cfg_index   = '0;
  logic [dsas_pkg::CfgDataW-1:0] cfg_data    = '0;
  logic                          in_stall;
  logic                          out_valid;
  dsas_pkg::out_t                out_data;
  int                            mismatches;
  int                            awaited;
  int                            idle_cycles = 0;
  bit                            rush        = 1'b0;
  bit                            sink_eager  = 1'b0;
  logic [dsas_pkg::LaneW-1:0]    pattern_pool[4];

  debounced_signal_auto_switch u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dsas_scoreboard u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (mismatches),
    .awaited_o   (awaited)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_n <= 1'b1;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stall before each transfer
  initial begin : sink
    int hold;
    wait (rst_n);
    forever begin
      if (sink_eager || $urandom_range(3, 0) == 0) begin
        hold = 0;
      end else begin
        hold = $urandom_range(18, 0);
      end
      repeat (hold) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  function automatic dsas_pkg::in_t make_item(logic [1:0] op,
                                              logic [dsas_pkg::LaneW-1:0] bits,
                                              logic [dsas_pkg::CountW-1:0] cnt,
                                              logic [dsas_pkg::NumW-1:0] num);
    dsas_pkg::in_t item;
    item.opcode       = op;
    item.sig_bits     = bits;
    item.sig_count    = cnt;
    item.input_number = num;
    return item;
  endfunction

  // random item, mostly reports and ticks so that debouncing gets through
  function automatic dsas_pkg::in_t random_item();
    dsas_pkg::in_t item;
    int            pick;
    item = dsas_pkg::in_t'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      item.opcode = dsas_pkg::OP_TICK;
    end else if (pick < 75) begin
      item.opcode = dsas_pkg::OP_REPORT;
      pick = $urandom_range(9, 0);
      if (pick < 5) begin
        item.sig_count = dsas_pkg::CountW'(dsas_pkg::LaneW);
      end else if (pick < 8) begin
        item.sig_count = dsas_pkg::CountW'($urandom_range(15, 1));
      end else begin
        item.sig_count = dsas_pkg::CountW'($urandom_range(31, 0));
      end
      if ($urandom_range(9, 0) < 7) begin
        item.sig_bits = pattern_pool[2'($urandom_range(3, 0))];
      end
    end else if (pick < 92) begin
      item.opcode = dsas_pkg::OP_SELECT;
      pick = $urandom_range(9, 0);
      if (pick < 6) begin
        item.input_number = dsas_pkg::NumW'($urandom_range(16, 1));
      end else if (pick == 6) begin
        item.input_number = '0;
      end
    end else begin
      item.opcode = OP_UNUSED;
    end
    return item;
  endfunction

  // one input transfer after a random gap
  task automatic send(dsas_pkg::in_t item);
    int gap;
    if (rush || $urandom_range(2, 0) == 0) begin
      gap = 0;
    end else begin
      gap = $urandom_range(18, 0);
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
  endtask

  // hold off input until every expected result is out
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(dsas_pkg::cfg_idx_e idx, logic [dsas_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    wait (rst_n);

    // default configuration: long debounce
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));
    send(make_item(dsas_pkg::OP_SELECT, '1, '1, 8'd0));
    send(make_item(dsas_pkg::OP_SELECT, '0, '0, 8'd255));
    send(make_item(OP_UNUSED, '1, '1, '1));
    send(make_item(dsas_pkg::OP_REPORT, '1, 5'd0, '1));
    send(make_item(dsas_pkg::OP_REPORT, '1, 5'd31, '0));
    send(make_item(dsas_pkg::OP_TICK, '1, '1, '1));

    // no debounce: selection, full-width reports, switch on a partial report
    settle();
    write_reg(dsas_pkg::CFG_DEBOUNCE, 16'd0);
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));
    send(make_item(dsas_pkg::OP_SELECT, '0, '0, 8'd16));
    send(make_item(dsas_pkg::OP_REPORT, 16'h0000, 5'd16, '0));
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));
    send(make_item(dsas_pkg::OP_REPORT, 16'h8000, 5'd16, '0));
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));
    send(make_item(dsas_pkg::OP_REPORT, 16'hFFFF, 5'd3, '0));
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));
    send(make_item(dsas_pkg::OP_REPORT, 16'h5555, 5'd1, '0));
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));

    // switching off, longest debounce, ticks still counted while off
    settle();
    write_reg(dsas_pkg::CFG_AUTO_SWITCH, 16'd0);
    write_reg(dsas_pkg::CFG_DEBOUNCE, 16'hFFFF);
    send(make_item(dsas_pkg::OP_REPORT, 16'hAAAA, 5'd16, '0));
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));
    rush       = 1'b1;
    sink_eager = 1'b1;
    repeat (40) send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));
    settle();
    write_reg(dsas_pkg::CFG_AUTO_SWITCH, 16'd1);
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));
    send(make_item(dsas_pkg::OP_TICK, '0, '0, '0));

    // random phases, each with its own settings and signal patterns
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      write_reg(dsas_pkg::CFG_AUTO_SWITCH, ($urandom_range(9, 0) < 8) ? 16'd1 : 16'd0);
      case ($urandom_range(9, 0))
        0:       write_reg(dsas_pkg::CFG_DEBOUNCE, 16'd0);
        1:       write_reg(dsas_pkg::CFG_DEBOUNCE, 16'hFFFF);
        2, 3:    write_reg(dsas_pkg::CFG_DEBOUNCE,
                           dsas_pkg::CfgDataW'($urandom_range(40, 7)));
        default: write_reg(dsas_pkg::CFG_DEBOUNCE,
                           dsas_pkg::CfgDataW'($urandom_range(6, 0)));
      endcase
      pattern_pool[0] = '0;
      for (int k = 1; k < 4; k++) begin
        pattern_pool[k] = dsas_pkg::LaneW'($urandom);
      end
      rush       = ($urandom_range(3, 0) == 0);
      sink_eager = ($urandom_range(3, 0) == 0);
      repeat (250) send(random_item());
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
